/* rtl/eia_pkg.sv */
// ----------------------------------------------------------------------------
// eia_pkg
// Shared types and constants of the entity ID allocator: operation and
// status codes, controller states and stream field layout.
// ----------------------------------------------------------------------------
package eia_pkg;

  localparam int unsigned MAX_IDS = 1024;
  localparam int unsigned ID_W    = 10;
  localparam int unsigned ADDR_W  = $clog2(MAX_IDS);
  localparam int unsigned CNT_W   = $clog2(MAX_IDS + 1);

  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;

  // stream payload widths, rounded up to whole bytes
  localparam int unsigned IN_BITS  = OP_W + ID_W;
  localparam int unsigned OUT_BITS = ID_W + 1 + STATUS_W;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_VALID = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    status_e           status;
    logic              is_valid;
    logic [ID_W-1:0]   result_id;
  } result_t;

endpackage

/* rtl/eia_ram.sv */
// ----------------------------------------------------------------------------
// eia_ram
// Simple dual-port synchronous memory, one write and one read port, with
// registered read data.
// ----------------------------------------------------------------------------
module eia_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/entity_id_allocator_core.sv */
// ----------------------------------------------------------------------------
// entity_id_allocator_core
// Hands out and takes back entity IDs: a valid bit per ID and a LIFO stack
// of freed IDs, both in synchronous memories, plus a high-water counter.
// ----------------------------------------------------------------------------
// usage
//   request stream (s_axis): operation and entity_id; create, destroy,
//   query valid or clear all. every request gives exactly one response on
//   the m_axis stream: result_id, is_valid and status.
//   timing: a request is read from both memories in the cycle it is taken,
//   and the following cycle modifies, writes back and loads the response
//   register. a new request is taken while the previous response still
//   waits in the output register; if the receiver stalls, the block holds
//   in its execute state until the output register frees, then commits.
//   reset clears the counters and empties the output register; memory
//   contents are never cleared. valid bits are only trusted below the
//   high-water counter, and stack entries only below the free count, so
//   reset and clear need no clearing pass.
// ----------------------------------------------------------------------------
module entity_id_allocator_core
  import eia_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // operation [1:0], entity_id [11:2], zero [15:12]
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // result_id [9:0], is_valid [10], status [12:11], zero [15:13]
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_IDS);
  localparam logic [CNT_W-1:0] OneCnt = CNT_W'(1);

  state_e state_q, state_d;

  op_e             op_q;
  logic [ID_W-1:0] id_q;
  logic [CNT_W-1:0] free_cnt_q, free_cnt_d, issued_cnt_q, issued_cnt_d;
  logic [CNT_W-1:0] free_dec;

  logic    m_valid_q, m_valid_d;
  result_t res_q, res_d;

  logic accept, out_free, commit;

  logic              vbit_rdata;
  logic              vbit_we_raw;
  logic [ADDR_W-1:0] vbit_waddr;
  logic              vbit_wdata;

  logic [ID_W-1:0]   stk_rdata;
  logic              stk_we_raw;
  logic [ADDR_W-1:0] stk_waddr;

  logic id_valid;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign commit   = (state_q == ST_EXEC) && out_free;
  assign free_dec = free_cnt_q - OneCnt;

  eia_ram #(
    .DEPTH (MAX_IDS),
    .WIDTH (1)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (commit && vbit_we_raw),
    .waddr_i (vbit_waddr),
    .wdata_i (vbit_wdata),
    .re_i    (accept),
    .raddr_i (s_axis_tdata[OP_W +: ADDR_W]),
    .rdata_o (vbit_rdata)
  );

  eia_ram #(
    .DEPTH (MAX_IDS),
    .WIDTH (ID_W)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (commit && stk_we_raw),
    .waddr_i (stk_waddr),
    .wdata_i (id_q),
    .re_i    (accept),
    .raddr_i (free_dec[ADDR_W-1:0]),
    .rdata_o (stk_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EXEC: s_axis_tready = 1'b0;
      default: s_axis_tready = 1'b0;
    endcase
  end

  assign id_valid = (CNT_W'(id_q) < issued_cnt_q) && vbit_rdata;

  // read-modify-write of the fetched entries
  always_comb begin
    res_d.result_id = id_q;
    res_d.is_valid  = 1'b0;
    res_d.status    = STATUS_OK;
    vbit_we_raw     = 1'b0;
    vbit_waddr      = id_q;
    vbit_wdata      = 1'b0;
    stk_we_raw      = 1'b0;
    stk_waddr       = free_cnt_q[ADDR_W-1:0];
    free_cnt_d      = free_cnt_q;
    issued_cnt_d    = issued_cnt_q;
    unique case (op_q)
      OP_CREATE: begin
        if (free_cnt_q != '0) begin
          res_d.result_id = stk_rdata;
          res_d.is_valid  = 1'b1;
          vbit_we_raw     = 1'b1;
          vbit_waddr      = stk_rdata;
          vbit_wdata      = 1'b1;
          free_cnt_d      = free_dec;
        end else if (issued_cnt_q < MaxCnt) begin
          res_d.result_id = issued_cnt_q[ID_W-1:0];
          res_d.is_valid  = 1'b1;
          vbit_we_raw     = 1'b1;
          vbit_waddr      = issued_cnt_q[ADDR_W-1:0];
          vbit_wdata      = 1'b1;
          issued_cnt_d    = issued_cnt_q + OneCnt;
        end else begin
          res_d.result_id = '0;
          res_d.status    = STATUS_FULL;
        end
      end
      OP_DESTROY: begin
        if (id_valid) begin
          vbit_we_raw = 1'b1;
          if (free_cnt_q < MaxCnt) begin
            stk_we_raw = 1'b1;
            free_cnt_d = free_cnt_q + OneCnt;
          end
        end else begin
          res_d.status = STATUS_NOT_VALID;
        end
      end
      OP_QUERY: begin
        res_d.is_valid = id_valid;
      end
      OP_CLEAR: begin
        free_cnt_d   = '0;
        issued_cnt_d = '0;
      end
      default: begin
        res_d.status = STATUS_OK;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (commit) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      free_cnt_q   <= '0;
      issued_cnt_q <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (commit) begin
        free_cnt_q   <= free_cnt_d;
        issued_cnt_q <= issued_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_e'(s_axis_tdata[OP_W-1:0]);
      id_q <= s_axis_tdata[OP_W +: ID_W];
    end
    if (commit) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'(res_q);

endmodule

/* rtl/eia_checker.sv */
// ----------------------------------------------------------------------------
// eia_checker
// Port-level checks of the entity ID allocator, bound to the top level.
// ----------------------------------------------------------------------------
module eia_checker
  import eia_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned ValidBit = ID_W;
  localparam int unsigned StatusLo = ID_W + 1;

  logic [ID_W-1:0]     rsp_id;
  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;

  assign rsp_id     = m_axis_tdata[ID_W-1:0];
  assign rsp_valid  = m_axis_tdata[ValidBit];
  assign rsp_status = m_axis_tdata[StatusLo +: STATUS_W];

  // one request in work at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while previous one in work");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_FULL ||
                       rsp_status == STATUS_NOT_VALID))
    else $error("unknown status code");

  a_full_response: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && rsp_status == STATUS_FULL) |-> (rsp_id == '0 && !rsp_valid))
    else $error("full response carries an id");

  a_valid_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && rsp_valid) |-> (rsp_status == STATUS_OK))
    else $error("valid id with error status");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled response changed");

endmodule

bind entity_id_allocator_core eia_checker u_eia_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/entity_id_allocator_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// entity_id_allocator_checker
// Watches the request and response streams of the ID allocator, tracks the
// valid bits, the freed-ID stack and the high-water counter on its own, and
// compares every response field with the oldest predicted response.
// ----------------------------------------------------------------------------
module entity_id_allocator_checker
  import eia_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_ready_i,
  // operation [1:0], entity_id [11:2], zero [15:12]
  input  logic [IN_W-1:0]  req_data_i,
  input  logic             rsp_valid_i,
  input  logic             rsp_ready_i,
  // result_id [9:0], is_valid [10], status [12:11], zero [15:13]
  input  logic [OUT_W-1:0] rsp_data_i,
  output int unsigned      mismatch_count_o,
  output int unsigned      pending_o
);

  logic            id_live   [MAX_IDS];
  logic [ID_W-1:0] freed_ids [MAX_IDS];
  int unsigned     freed_cnt;
  int unsigned     issued_cnt;
  result_t         expected_responses [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count_o++;
  endtask

  function automatic void clear_tracking();
    for (int i = 0; i < MAX_IDS; i++) id_live[i] = 1'b0;
    freed_cnt  = 0;
    issued_cnt = 0;
  endfunction

  function automatic result_t predict_allocation(input op_e op, input logic [ID_W-1:0] id);
    result_t r;
    r.result_id = id;
    r.is_valid  = 1'b0;
    r.status    = STATUS_OK;
    case (op)
      OP_CREATE: begin
        if (freed_cnt > 0) begin
          freed_cnt--;
          r.result_id = freed_ids[freed_cnt];
          id_live[r.result_id] = 1'b1;
          r.is_valid = 1'b1;
        end else if (issued_cnt < MAX_IDS) begin
          r.result_id = ID_W'(issued_cnt);
          id_live[r.result_id] = 1'b1;
          issued_cnt++;
          r.is_valid = 1'b1;
        end else begin
          r.result_id = '0;
          r.status    = STATUS_FULL;
        end
      end
      OP_DESTROY: begin
        if (id_live[id]) begin
          id_live[id] = 1'b0;
          if (freed_cnt < MAX_IDS) begin
            freed_ids[freed_cnt] = id;
            freed_cnt++;
          end
        end else begin
          r.status = STATUS_NOT_VALID;
        end
      end
      OP_QUERY: r.is_valid = id_live[id];
      default:  clear_tracking();
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t got;
    result_t want;
    if (!rst_ni) begin
      clear_tracking();
      expected_responses.delete();
      pending_o = 0;
    end else begin
      if (req_valid_i && req_ready_i) begin
        want = predict_allocation(op_e'(req_data_i[OP_W-1:0]), req_data_i[OP_W +: ID_W]);
        expected_responses = {expected_responses, want};
      end
      if (rsp_valid_i && rsp_ready_i) begin
        got = result_t'(rsp_data_i[OUT_BITS-1:0]);
        if (expected_responses.size() == 0) begin
          report_mismatch($sformatf("response with none expected, result_id %0d",
                                    got.result_id));
        end else begin
          want = expected_responses.pop_front();
          if (got.result_id !== want.result_id)
            report_mismatch($sformatf("result_id got %0d expected %0d",
                                      got.result_id, want.result_id));
          if (got.is_valid !== want.is_valid)
            report_mismatch($sformatf("is_valid got %0d expected %0d for id %0d",
                                      got.is_valid, want.is_valid, want.result_id));
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d for id %0d",
                                      got.status, want.status, want.result_id));
        end
      end
      pending_o = expected_responses.size();
    end
  end

endmodule

/* tb/sv/entity_id_allocator_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// entity_id_allocator_core_tb
// Drives create, destroy, query and clear requests into the ID allocator:
// a directed opening, random mixes on small and full ID ranges, and a run
// that fills every ID and pushes past full. Both stream sides idle at
// random; the checker beside the block predicts and compares responses.
// ----------------------------------------------------------------------------
module entity_id_allocator_core_tb;
  import eia_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  int unsigned      mismatch_count;
  int unsigned      pending;
  logic             no_idle;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  entity_id_allocator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  entity_id_allocator_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (s_axis_tvalid),
    .req_ready_i      (s_axis_tready),
    .req_data_i       (s_axis_tdata),
    .rsp_valid_i      (m_axis_tvalid),
    .rsp_ready_i      (m_axis_tready),
    .rsp_data_i       (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  task automatic send_item(input op_e op, input logic [ID_W-1:0] id);
    int unsigned gap;
    if ($urandom_range(0, 49) == 0) no_idle <= ~no_idle;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W-IN_BITS){1'b0}}, id, op};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  task automatic send_mixed(input int n, input int unsigned id_span, input bit with_clear);
    int unsigned      r;
    logic [ID_W-1:0]  id;
    for (int i = 0; i < n; i++) begin
      r  = $urandom_range(0, 99);
      id = ($urandom_range(0, 4) == 0) ? ID_W'($urandom_range(0, MAX_IDS - 1))
                                       : ID_W'($urandom_range(0, id_span));
      if (r < 40)                    send_item(OP_CREATE, id);
      else if (r < 68)               send_item(OP_DESTROY, id);
      else if (r < 96 || !with_clear) send_item(OP_QUERY, id);
      else                           send_item(OP_CLEAR, id);
    end
  endtask

  // every ID taken, then creates past full
  task automatic fill_to_capacity();
    int n_create;
    n_create = 0;
    send_item(OP_CLEAR, ID_W'($urandom_range(0, MAX_IDS - 1)));
    while (n_create < MAX_IDS + 6) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(OP_QUERY, ID_W'($urandom_range(0, MAX_IDS - 1)));
      end else begin
        send_item(OP_CREATE, ID_W'($urandom_range(0, MAX_IDS - 1)));
        n_create++;
      end
    end
  endtask

  initial begin
    int unsigned gap;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    no_idle       = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_QUERY,   10'd0);
    send_item(OP_DESTROY, 10'd5);
    send_item(OP_CREATE,  10'd0);
    send_item(OP_CREATE,  10'd1023);
    send_item(OP_CREATE,  10'd0);
    send_item(OP_QUERY,   10'd1);
    send_item(OP_DESTROY, 10'd1);
    send_item(OP_DESTROY, 10'd1);
    send_item(OP_DESTROY, 10'd0);
    send_item(OP_CREATE,  10'd0);
    send_item(OP_CREATE,  10'd0);
    send_item(OP_CREATE,  10'd0);
    send_item(OP_QUERY,   10'd1023);
    send_item(OP_DESTROY, 10'd1023);
    send_item(OP_CLEAR,   10'd1023);
    send_item(OP_CREATE,  10'd0);
    send_item(OP_CREATE,  10'd0);
    send_item(OP_CREATE,  10'd0);
    send_item(OP_DESTROY, 10'd2);
    // clear must also drop the freed stack
    send_item(OP_CLEAR,   10'd0);
    send_item(OP_CREATE,  10'd0);
    send_item(OP_CREATE,  10'd0);
    send_item(OP_QUERY,   10'd2);
    send_item(OP_QUERY,   10'd1);

    send_mixed(800, 31, 1'b1);
    pause_until_drained();
    fill_to_capacity();
    send_mixed(80, MAX_IDS - 1, 1'b0);
    send_mixed(200, 63, 1'b1);

    pause_until_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* entity_id_allocator_core.f */
rtl/eia_pkg.sv
rtl/eia_ram.sv
rtl/entity_id_allocator_core.sv
rtl/eia_checker.sv
tb/sv/entity_id_allocator_checker.sv
tb/sv/entity_id_allocator_core_tb.sv
